// File: rtl/core/dcm_to_quaternion_top_assert.svh
// Assertion macros for the DCM to quaternion block.
// Used by dcm_to_quaternion_top.sv; no other dependencies.
`ifndef DCM_TO_QUATERNION_TOP_ASSERT_SVH
`define DCM_TO_QUATERNION_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DCQ_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define DCQ_ASSERT_NR(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define DCQ_ASSERT(lbl, ck, rn, prop, msg)
`define DCQ_ASSERT_NR(lbl, ck, prop, msg)
`endif
`endif

// File: rtl/core/dcq_pkg.sv
// Types and constants for the DCM to quaternion pipeline.
// No dependencies.
package dcq_pkg;
  localparam int ELEM_W  = 32;
  localparam int WIDE_W  = 35;
  localparam int MAG_W   = 31;
  localparam int ROOT_W  = 32;
  localparam int RAD_W   = 64;
  localparam int SQR_W   = 36;
  localparam int LANES   = 4;
  localparam int IN_W    = 9 * ELEM_W;
  localparam int OUT_W   = LANES * ELEM_W;

  localparam logic signed [WIDE_W-1:0] Q_ONE = WIDE_W'(1) <<< 30;
  localparam logic [ELEM_W-1:0] Q_ONE_OUT = ELEM_W'(1) << 30;

  typedef logic [MAG_W-1:0]            mag_t;
  typedef logic [LANES-1:0][MAG_W-1:0] mag4_t;
  typedef logic [LANES-1:0]            sgn_t;
  typedef logic [LANES-1:0][ROOT_W-1:0] rem4_t;
endpackage

// File: rtl/core/dcm_to_quaternion_top.sv
// DCM to quaternion converter (Shepperd's method), Q2.30, fully pipelined.
// Depends on dcq_pkg and dcm_to_quaternion_top_assert.svh.
//
//  channel | dir | tdata fields (low bit up)
//  in_     | in  | m00 m01 m02 m10 m11 m12 m20 m21 m22, 32 bits each
//  out_    | out | qw qx qy qz, 32 bits each
//
// Stages: branch select, square, two adder stages, 32 square-root
// stages (one root bit each), one setup and 31 divider stages (one quotient
// bit each, four lanes), output register. One matrix per cycle.
// All stages advance together whenever the output register is empty or taken.
// Reset clears the valid bits only.
`include "dcm_to_quaternion_top_assert.svh"
module dcm_to_quaternion_top
  import dcq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,   // m00,m01,m02,m10,m11,m12,m20,m21,m22
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata   // qw,qx,qy,qz
);

  localparam int SQ_N  = ROOT_W;
  localparam int DV_N  = MAG_W;

  logic en;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------- stage 1: branch select and component vector
  logic signed [WIDE_W-1:0] e [0:8];
  logic signed [WIDE_W-1:0] tr, vw, vx, vy, vz;
  logic                     bad;
  logic signed [WIDE_W-1:0] v [0:3];
  mag4_t a_nxt;
  sgn_t  s_nxt;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      e[i] = WIDE_W'($signed(in_tdata[i*ELEM_W +: ELEM_W]));
    end
    tr = e[0] + e[4] + e[8];
    bad = 1'b0;
    if (tr > 0) begin
      vw = Q_ONE + tr;       vx = e[7] - e[5];
      vy = e[2] - e[6];      vz = e[3] - e[1];
    end else if (e[0] > e[4] && e[0] > e[8]) begin
      vw = e[7] - e[5];      vx = Q_ONE + e[0] - e[4] - e[8];
      vy = e[1] + e[3];      vz = e[2] + e[6];
      bad = (vx <= 0);
    end else if (e[4] > e[8]) begin
      vw = e[2] - e[6];      vx = e[1] + e[3];
      vy = Q_ONE + e[4] - e[0] - e[8];
      vz = e[5] + e[7];
      bad = (vy <= 0);
    end else begin
      vw = e[3] - e[1];      vx = e[2] + e[6];
      vy = e[5] + e[7];      vz = Q_ONE + e[8] - e[0] - e[4];
      bad = (vz <= 0);
    end
    v[0] = vw; v[1] = vx; v[2] = vy; v[3] = vz;
    for (int i = 0; i < LANES; i++) begin
      s_nxt[i] = v[i][WIDE_W-1];
      a_nxt[i] = v[i][WIDE_W-1] ? MAG_W'((-v[i]) >>> 2) : MAG_W'(v[i] >>> 2);
    end
  end

  logic  p1_vld_r, p2_vld_r, p3_vld_r;
  mag4_t p1_a_r, p2_a_r, p3_a_r;
  sgn_t  p1_s_r, p2_s_r, p3_s_r;
  logic  p1_id_r, p2_id_r, p3_id_r;
  logic [LANES-1:0][2*MAG_W-1:0] p2_sq_r;
  logic [1:0][2*MAG_W:0]         p3_ps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= in_tvalid;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_a_r  <= a_nxt;
      p1_s_r  <= s_nxt;
      p1_id_r <= bad;
      // square each magnitude
      for (int i = 0; i < LANES; i++) begin
        p2_sq_r[i] <= (2*MAG_W)'(p1_a_r[i]) * (2*MAG_W)'(p1_a_r[i]);
      end
      p2_a_r  <= p1_a_r;
      p2_s_r  <= p1_s_r;
      p2_id_r <= p1_id_r;
      p3_ps_r[0] <= (2*MAG_W+1)'(p2_sq_r[0]) + (2*MAG_W+1)'(p2_sq_r[1]);
      p3_ps_r[1] <= (2*MAG_W+1)'(p2_sq_r[2]) + (2*MAG_W+1)'(p2_sq_r[3]);
      p3_a_r  <= p2_a_r;
      p3_s_r  <= p2_s_r;
      p3_id_r <= p2_id_r;
    end
  end

  // ---------------- square root: one root bit per stage
  logic              sq_vld_r [0:SQ_N];
  logic [RAD_W-1:0]  sq_rad_r [0:SQ_N];
  logic [SQR_W-1:0]  sq_rem_r [0:SQ_N];
  logic [ROOT_W-1:0] sq_root_r[0:SQ_N];
  mag4_t             sq_a_r   [0:SQ_N];
  sgn_t              sq_s_r   [0:SQ_N];
  logic              sq_id_r  [0:SQ_N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else if (en) begin
      sq_vld_r[0] <= p3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rad_r[0]  <= RAD_W'(p3_ps_r[0]) + RAD_W'(p3_ps_r[1]);
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_a_r[0]    <= p3_a_r;
      sq_s_r[0]    <= p3_s_r;
      sq_id_r[0]   <= p3_id_r;
    end
  end

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    logic [SQR_W-1:0] remx, trial;
    logic             take;
    assign remx  = {sq_rem_r[k][SQR_W-3:0], sq_rad_r[k][RAD_W-1 -: 2]};
    assign trial = SQR_W'({sq_root_r[k], 2'b01});
    assign take  = (remx >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k+1] <= 1'b0;
      end else if (en) begin
        sq_vld_r[k+1] <= sq_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rad_r[k+1]  <= sq_rad_r[k] << 2;
        sq_rem_r[k+1]  <= take ? remx - trial : remx;
        sq_root_r[k+1] <= {sq_root_r[k][ROOT_W-2:0], take};
        sq_a_r[k+1]    <= sq_a_r[k];
        sq_s_r[k+1]    <= sq_s_r[k];
        sq_id_r[k+1]   <= sq_id_r[k];
      end
    end
  end

  // ---------------- divider: one quotient bit per stage, four lanes
  logic              dv_vld_r [0:DV_N];
  logic [ROOT_W-1:0] dv_n_r   [0:DV_N];
  rem4_t             dv_rem_r [0:DV_N];
  mag4_t             dv_low_r [0:DV_N];
  mag4_t             dv_q_r   [0:DV_N];
  sgn_t              dv_s_r   [0:DV_N];
  logic              dv_id_r  [0:DV_N];

  logic [ROOT_W-1:0] nroot;
  logic [2*MAG_W-1:0] num [0:LANES-1];
  rem4_t rem0;
  mag4_t low0;
  assign nroot = sq_root_r[SQ_N];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      // numerator a*2^30 + floor(n/2)
      num[i]  = {1'b0, sq_a_r[SQ_N][i], 30'b0} + (2*MAG_W)'(nroot >> 1);
      rem0[i] = ROOT_W'(num[i][2*MAG_W-1:MAG_W]);
      low0[i] = num[i][MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (en) begin
      dv_vld_r[0] <= sq_vld_r[SQ_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_n_r[0]   <= nroot;
      dv_rem_r[0] <= rem0;
      dv_low_r[0] <= low0;
      dv_q_r[0]   <= '0;
      dv_s_r[0]   <= sq_s_r[SQ_N];
      dv_id_r[0]  <= sq_id_r[SQ_N] || (nroot == '0);
    end
  end

  for (genvar k = 0; k < DV_N; k++) begin : g_div
    rem4_t rem_nxt;
    mag4_t q_nxt;
    always_comb begin
      logic [ROOT_W:0] rx;
      for (int i = 0; i < LANES; i++) begin
        rx = {dv_rem_r[k][i], dv_low_r[k][i][MAG_W-1]};
        if (rx >= {1'b0, dv_n_r[k]}) begin
          rem_nxt[i] = ROOT_W'(rx - {1'b0, dv_n_r[k]});
          q_nxt[i]   = {dv_q_r[k][i][MAG_W-2:0], 1'b1};
        end else begin
          rem_nxt[i] = ROOT_W'(rx);
          q_nxt[i]   = {dv_q_r[k][i][MAG_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_vld_r[k+1] <= dv_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_n_r[k+1]   <= dv_n_r[k];
        dv_rem_r[k+1] <= rem_nxt;
        for (int i = 0; i < LANES; i++) begin
          dv_low_r[k+1][i] <= dv_low_r[k][i] << 1;
        end
        dv_q_r[k+1]   <= q_nxt;
        dv_s_r[k+1]   <= dv_s_r[k];
        dv_id_r[k+1]  <= dv_id_r[k];
      end
    end
  end

  // ---------------- output register
  logic              out_vld_r;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;
  logic              out_id_r;

  always_comb begin
    logic [ELEM_W-1:0] qm;
    for (int i = 0; i < LANES; i++) begin
      qm = {1'b0, dv_q_r[DV_N][i]};
      out_data_nxt[i*ELEM_W +: ELEM_W] = dv_s_r[DV_N][i] ? -qm : qm;
    end
    if (dv_id_r[DV_N]) begin
      out_data_nxt = OUT_W'(Q_ONE_OUT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld_r[DV_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
      out_id_r   <= dv_id_r[DV_N];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  `DCQ_ASSERT(a_hold_on_stall, clk, rst_n, !en |=> $stable(dv_q_r[DV_N]) && $stable(out_data_r), "pipeline moved while stalled")
  `DCQ_ASSERT(a_div_rem_bound, clk, rst_n, dv_vld_r[DV_N] && !dv_id_r[DV_N] |-> dv_rem_r[DV_N][0] < dv_n_r[DV_N], "divider remainder not below divisor")
  `DCQ_ASSERT(a_identity_out, clk, rst_n, out_vld_r && out_id_r |-> out_data_r == OUT_W'(Q_ONE_OUT), "identity quaternion expected")

endmodule
